[rtl/core/mgc_pkg.sv]
`default_nettype none

package mgc_pkg;

    localparam int NONTERMINALS_DEF = 32;
    localparam int MAX_LEVELS_DEF   = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam int SYM_W   = 6;
    localparam int LEVEL_W = 4;
    localparam int COORD_W = 8;

    localparam logic [SYM_W-1:0]   TERMINALS    = 6'd16;
    localparam logic [LEVEL_W-1:0] LEVELS_RESET = 4'd5;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    localparam logic [1:0] CODE_ZERO       = 2'd0;
    localparam logic [1:0] CODE_ONE        = 2'd1;
    localparam logic [1:0] CODE_VOID       = 2'd2;
    localparam logic [1:0] CODE_UNRESOLVED = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_LEVELS = 1'b0;

    typedef enum logic
    {
        CMD_WRITE,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t          kind;
        logic [4:0]         lhs;
        logic [1:0]         slot;
        logic [SYM_W-1:0]   symbol;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [LEVEL_W-1:0] depth;
    } cmd_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_WALK,
        BK_HOLD
    } back_state_t;

    typedef struct packed
    {
        logic busy;
        logic walking;
    } back_status_t;

    // slot = row bit + 2 * column bit; positions past the coordinate width read zero
    function automatic logic [1:0] slot_at(logic [COORD_W-1:0] row,
                                           logic [COORD_W-1:0] col,
                                           logic [LEVEL_W-1:0] pos);
        logic [1:0] s;
        if (pos[3])
        begin
            s = 2'b00;
        end
        else
        begin
            s = {col[pos[2:0]], row[pos[2:0]]};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mgc_if.sv]
`default_nettype none

interface mgc_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [4:0] rule_lhs;
    logic [1:0] rule_slot;
    logic [5:0] rule_symbol;
    logic [7:0] cell_row;
    logic [7:0] cell_col;

    modport source
    (
        output valid, action, rule_lhs, rule_slot, rule_symbol, cell_row, cell_col,
        input  ready
    );

    modport sink
    (
        input  valid, action, rule_lhs, rule_slot, rule_symbol, cell_row, cell_col,
        output ready
    );
endinterface

interface mgc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_code;

    modport source
    (
        output valid, cell_code,
        input  ready
    );

    modport sink
    (
        input  valid, cell_code,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/matrix_grammar_cell_decoder.sv]
// Matrix grammar cell decoder. The block keeps the rewrite table of a 2x2 matrix grammar
// (four right-hand symbols for each nonterminal) and answers cell queries on the matrix
// that the start symbol expands to over the configured number of levels. Write items
// (action 0) store one rule slot and return nothing; query items (action 1) return one
// cell_code: 0 no connection, 1 connection, 2 void (an unwritten rule was met),
// 3 unresolved (a symbol is left after the last level). The rule store comes out of reset
// all void; valid bits are cleared at once, so there is no clearing pass. Items pass a
// front register and a two-entry queue before the back end; the back end stores a write
// from its idle state and makes up to depth lookups for a query, depth being the level
// count clamped to one..MAX_LEVELS, because each level is a dependent read of the rule
// store through its single registered read port. The reset level count is five; the
// response register lets the next item start while a result waits to be taken. The
// levels register is written over the APB port at byte address 0 and should be changed
// only while the block is idle.
`default_nettype none

module matrix_grammar_cell_decoder #(
    parameter int NONTERMINALS = mgc_pkg::NONTERMINALS_DEF,
    parameter int MAX_LEVELS   = mgc_pkg::MAX_LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mgc_req_if.sink     req,
    mgc_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mgc_pkg::*;

    logic [LEVEL_W-1:0] levels_reg;
    logic               cfg_wr;
    logic               sel_levels;

    cmd_t               front_cmd;
    logic               front_valid;
    logic               front_ready;
    cmd_t               queue_cmd;
    logic               queue_valid;
    logic               queue_ready;
    back_status_t       bk_status;

    // ---------------------------------------------------------------------------------
    // Configuration: one register, word index in paddr[2]; writes elsewhere are dropped
    // ---------------------------------------------------------------------------------
    assign pready     = 1'b1;
    assign sel_levels = (paddr[2] == REG_LEVELS);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign prdata     = sel_levels ? {28'd0, levels_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
        end
        else if (cfg_wr && sel_levels)
        begin
            levels_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // ---------------------------------------------------------------------------------
    // Front: accept, classify, drop writes with no storage, clamp the level count
    // ---------------------------------------------------------------------------------
    mgc_front #(
        .NONTERMINALS (NONTERMINALS),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .levels    (levels_reg),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // ---------------------------------------------------------------------------------
    // Queue: decouple the front from the lookup walk
    // ---------------------------------------------------------------------------------
    mgc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (queue_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    // ---------------------------------------------------------------------------------
    // Back: rule store writes, level-by-level walk, response register
    // ---------------------------------------------------------------------------------
    mgc_back #(
        .NONTERMINALS (NONTERMINALS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .rsp       (rsp),
        .status    (bk_status)
    );

    // ---------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------

    // hold a classified item in the front register while the queue is full
    a_front_hold : assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(front_cmd))
        else $error("front item changed while the queue was full");

    // a new response only comes out of a busy back end
    a_rsp_from_walk : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(bk_status.busy))
        else $error("response raised without a query in the back end");

    // a walking back end takes no new command from the queue
    a_walk_no_pop : assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.walking |-> !queue_ready)
        else $error("back end took a command during a walk");

    // a write to the levels register lands in the next cycle
    a_cfg_levels : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && sel_levels |=> levels_reg == $past(pwdata[LEVEL_W-1:0]))
        else $error("levels register did not take the written value");

endmodule

`default_nettype wire

[rtl/core/mgc_front.sv]
`default_nettype none

module mgc_front #(
    parameter int NONTERMINALS = mgc_pkg::NONTERMINALS_DEF,
    parameter int MAX_LEVELS   = mgc_pkg::MAX_LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mgc_req_if.sink                      req,
    input  logic [mgc_pkg::LEVEL_W-1:0]  levels,
    output mgc_pkg::cmd_t                cmd,
    output logic                         cmd_valid,
    input  logic                         cmd_ready
);
    import mgc_pkg::*;

    localparam logic [LEVEL_W-1:0] MAX_DEPTH = LEVEL_W'(MAX_LEVELS);

    logic               valid_reg;
    logic               valid_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic               accept;
    logic               keep;
    logic [LEVEL_W-1:0] depth;

    assign req.ready = !valid_reg || cmd_ready;
    assign accept    = req.valid && req.ready;

    // clamp the level count to one..MAX_LEVELS
    always_comb
    begin
        depth = levels;
        if (levels == '0)
        begin
            depth = LEVEL_W'(1);
        end
        else if (levels > MAX_DEPTH)
        begin
            depth = MAX_DEPTH;
        end
    end

    // drop writes to nonterminals that have no storage
    assign keep = (req.action == ACTION_QUERY) || (int'(req.rule_lhs) < NONTERMINALS);

    always_comb
    begin
        cmd_next.kind   = (req.action == ACTION_QUERY) ? CMD_QUERY : CMD_WRITE;
        cmd_next.lhs    = req.rule_lhs;
        cmd_next.slot   = req.rule_slot;
        cmd_next.symbol = req.rule_symbol;
        cmd_next.row    = req.cell_row;
        cmd_next.col    = req.cell_col;
        cmd_next.depth  = depth;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = keep;
        end
        else
        begin
            valid_next = valid_reg && !cmd_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

`default_nettype wire

[rtl/core/mgc_queue.sv]
`default_nettype none

module mgc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  mgc_pkg::cmd_t push_cmd,
    input  logic          push_valid,
    output logic          push_ready,
    output mgc_pkg::cmd_t pop_cmd,
    output logic          pop_valid,
    input  logic          pop_ready
);
    import mgc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mgc_back.sv]
`default_nettype none

module mgc_back #(
    parameter int NONTERMINALS = mgc_pkg::NONTERMINALS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mgc_pkg::cmd_t         cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    mgc_rsp_if.source             rsp,
    output mgc_pkg::back_status_t status
);
    import mgc_pkg::*;

    localparam int DEPTH = NONTERMINALS * 4;
    localparam int AW    = $clog2(DEPTH);

    back_state_t        state_reg;
    back_state_t        state_next;

    logic [SYM_W-1:0]   sym_mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [SYM_W-1:0]   rd_sym_reg;
    logic               rd_valid_reg;

    logic [LEVEL_W-1:0] lvl_reg;
    logic [LEVEL_W-1:0] lvl_next;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic [1:0]         code_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         out_code_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               finish;
    logic [1:0]         step_code;
    logic [SYM_W-1:0]   walk_n;
    logic [LEVEL_W-1:0] walk_pos;
    logic [1:0]         walk_slot;
    logic [1:0]         first_slot;
    logic               out_free;
    logic               out_load;
    logic               hold_load;
    logic [1:0]         out_code_src;

    assign walk_n     = rd_sym_reg - TERMINALS;
    assign walk_pos   = lvl_reg - LEVEL_W'(1);
    assign walk_slot  = slot_at(row_reg, col_reg, walk_pos);
    assign first_slot = slot_at(cmd.row, cmd.col, cmd.depth - LEVEL_W'(1));
    assign wr_addr    = AW'({cmd.lhs, cmd.slot});
    assign out_free   = !out_valid_reg || rsp.ready;

    // one rule lookup per level; the read data of the last lookup decides the next
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        finish    = 1'b0;
        step_code = CODE_UNRESOLVED;
        lvl_next  = lvl_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == CMD_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        // start symbol is nonterminal zero
                        rd_en    = 1'b1;
                        rd_addr  = AW'({6'd0, first_slot});
                        lvl_next = cmd.depth - LEVEL_W'(1);
                        row_next = cmd.row;
                        col_next = cmd.col;
                    end
                end
            end
            BK_WALK:
            begin
                if (!rd_valid_reg)
                begin
                    finish    = 1'b1;
                    step_code = CODE_VOID;
                end
                else if (lvl_reg == '0)
                begin
                    finish    = 1'b1;
                    step_code = CODE_UNRESOLVED;
                end
                else if (rd_sym_reg < TERMINALS)
                begin
                    finish    = 1'b1;
                    step_code = rd_sym_reg[walk_slot] ? CODE_ONE : CODE_ZERO;
                end
                else if (int'(walk_n) >= NONTERMINALS)
                begin
                    finish    = 1'b1;
                    step_code = CODE_VOID;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'({walk_n, walk_slot});
                    lvl_next = lvl_reg - LEVEL_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_QUERY))
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (finish)
                begin
                    state_next = out_free ? BK_IDLE : BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready      = 1'b0;
        out_load       = 1'b0;
        hold_load      = 1'b0;
        out_code_src   = step_code;
        status.busy    = 1'b1;
        status.walking = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_ready   = 1'b1;
                status.busy = 1'b0;
            end
            BK_WALK:
            begin
                status.walking = 1'b1;
                out_load       = finish && out_free;
                hold_load      = finish && !out_free;
            end
            BK_HOLD:
            begin
                out_load     = out_free;
                out_code_src = code_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        row_reg <= row_next;
        col_reg <= col_next;
        if (hold_load)
        begin
            code_reg <= step_code;
        end
        if (out_load)
        begin
            out_code_reg <= out_code_src;
        end
    end

    // rule store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sym_mem[wr_addr] <= cmd.symbol;
        end
        if (rd_en)
        begin
            rd_sym_reg   <= sym_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.cell_code = out_code_reg;

endmodule

`default_nettype wire
